FILE: rtl/door_drive_profile_fsm_macros.svh
// ----------------------------------------------------------------------------
// door drive profile assertion macros
// shared property wrappers for the door drive checker
// ----------------------------------------------------------------------------
`ifndef DOOR_DRIVE_PROFILE_FSM_MACROS_SVH
`define DOOR_DRIVE_PROFILE_FSM_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define DDP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddp check failed");

// next-cycle implication
`define DDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddp check failed");

`endif

FILE: rtl/ddp_pkg.sv
// ----------------------------------------------------------------------------
// ddp_pkg
// types and constants shared by the door drive profile block
// ----------------------------------------------------------------------------
package ddp_pkg;

    localparam int MAG_W   = 15;
    localparam int SPEED_W = 16;
    localparam int PHASE_W = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [MAG_W-1:0] LOW_SPEED_RESET  = 15'd100;
    localparam logic [MAG_W-1:0] HIGH_SPEED_RESET = 15'd1000;

    // register index taken from the word address bit
    localparam logic REG_LOW_SPEED  = 1'b0;
    localparam logic REG_HIGH_SPEED = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        PH_HOMING     = 4'd0,
        PH_OPEN       = 4'd1,
        PH_CLOSED     = 4'd2,
        PH_ACC_POS    = 4'd3,
        PH_ACC_NEG    = 4'd4,
        PH_CRUISE_POS = 4'd5,
        PH_CRUISE_NEG = 4'd6,
        PH_DEC_POS    = 4'd7,
        PH_DEC_NEG    = 4'd8
    } phase_t;

    typedef struct packed {
        logic close_request;
        logic open_end_switch;
        logic open_near_switch;
        logic close_near_switch;
        logic close_end_switch;
    } ddp_item_t;

    typedef struct packed {
        logic [MAG_W-1:0] low_speed;
        logic [MAG_W-1:0] high_speed;
    } ddp_cfg_t;

endpackage

FILE: rtl/ddp_ifs.sv
// ----------------------------------------------------------------------------
// ddp interfaces
// valid/ready channels for switch ticks in and phase/speed results out
// ----------------------------------------------------------------------------
interface ddp_in_if;
    logic valid;
    logic ready;
    logic close_request;
    logic open_end_switch;
    logic open_near_switch;
    logic close_near_switch;
    logic close_end_switch;

    modport source (
        output valid, close_request, open_end_switch, open_near_switch,
               close_near_switch, close_end_switch,
        input  ready
    );
    modport sink (
        input  valid, close_request, open_end_switch, open_near_switch,
               close_near_switch, close_end_switch,
        output ready
    );
endinterface

interface ddp_out_if;
    logic              valid;
    logic              ready;
    logic [3:0]        phase_code;
    logic signed [15:0] drive_speed;

    modport source (
        output valid, phase_code, drive_speed,
        input  ready
    );
    modport sink (
        input  valid, phase_code, drive_speed,
        output ready
    );
endinterface

FILE: rtl/ddp_cfg.sv
// ----------------------------------------------------------------------------
// ddp_cfg
// apb register file holding the slow and fast speed magnitudes
// ----------------------------------------------------------------------------
module ddp_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddp_pkg::ADDR_W-1:0]  paddr,
    input  logic [ddp_pkg::DATA_W-1:0]  pwdata,
    output logic [ddp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ddp_pkg::ddp_cfg_t           cfg
);
    import ddp_pkg::*;

    logic [MAG_W-1:0] low_reg;
    logic [MAG_W-1:0] low_next;
    logic [MAG_W-1:0] high_reg;
    logic [MAG_W-1:0] high_next;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_LOW_SPEED:  low_next  = pwdata[MAG_W-1:0];
                REG_HIGH_SPEED: high_next = pwdata[MAG_W-1:0];
                default:        low_next  = low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= LOW_SPEED_RESET;
            high_reg <= HIGH_SPEED_RESET;
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LOW_SPEED:  prdata = {{(DATA_W-MAG_W){1'b0}}, low_reg};
            REG_HIGH_SPEED: prdata = {{(DATA_W-MAG_W){1'b0}}, high_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.low_speed  = low_reg;
    assign cfg.high_speed = high_reg;

endmodule

FILE: rtl/ddp_in_stage.sv
// ----------------------------------------------------------------------------
// ddp_in_stage
// input register for one tick of switch levels
// ----------------------------------------------------------------------------
module ddp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    ddp_in_if.sink             item_in,
    input  logic               take,
    output logic               item_valid,
    output ddp_pkg::ddp_item_t item
);
    import ddp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ddp_item_t item_reg;
    logic      accept;

    // slot frees up in the same cycle the fsm consumes it
    assign item_in.ready = !valid_reg || take;
    assign accept        = item_in.valid && item_in.ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.close_request     <= item_in.close_request;
            item_reg.open_end_switch   <= item_in.open_end_switch;
            item_reg.open_near_switch  <= item_in.open_near_switch;
            item_reg.close_near_switch <= item_in.close_near_switch;
            item_reg.close_end_switch  <= item_in.close_end_switch;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/ddp_fsm.sv
// ----------------------------------------------------------------------------
// ddp_fsm
// motion phase machine; phase and speed registers double as the result beat
// ----------------------------------------------------------------------------
module ddp_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  ddp_pkg::ddp_item_t item,
    input  ddp_pkg::ddp_cfg_t  cfg,
    output logic               take,
    ddp_out_if.source          result_out
);
    import ddp_pkg::*;

    phase_t                    phase_reg;
    phase_t                    phase_next;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [SPEED_W-1:0] speed_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [SPEED_W-1:0] low_pos;
    logic signed [SPEED_W-1:0] high_pos;
    logic                      to_close;

    assign low_pos  = $signed({1'b0, cfg.low_speed});
    assign high_pos = $signed({1'b0, cfg.high_speed});
    assign to_close = item.close_request;

    assign take = item_valid && (!out_valid_reg || result_out.ready);

    // next phase; direction is tested before the switches
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HOMING:
                if (to_close)
                begin
                    if (item.close_end_switch)
                        phase_next = PH_CLOSED;
                end
                else if (item.open_end_switch)
                    phase_next = PH_OPEN;
            PH_OPEN:
                if (to_close)
                    phase_next = PH_ACC_NEG;
            PH_CLOSED:
                if (!to_close)
                    phase_next = PH_ACC_POS;
            PH_ACC_POS:
                if (to_close)
                    phase_next = PH_DEC_NEG;
                else if (item.close_near_switch)
                    phase_next = PH_CRUISE_POS;
            PH_ACC_NEG:
                if (!to_close)
                    phase_next = PH_DEC_POS;
                else if (item.open_near_switch)
                    phase_next = PH_CRUISE_NEG;
            PH_CRUISE_POS:
                if (to_close)
                    phase_next = PH_CRUISE_NEG;
                else if (item.open_near_switch)
                    phase_next = PH_DEC_POS;
            PH_CRUISE_NEG:
                if (!to_close)
                    phase_next = PH_CRUISE_POS;
                else if (item.close_near_switch)
                    phase_next = PH_DEC_NEG;
            PH_DEC_POS:
                if (to_close)
                    phase_next = PH_ACC_NEG;
                else if (item.open_end_switch)
                    phase_next = PH_OPEN;
            PH_DEC_NEG:
                if (!to_close)
                    phase_next = PH_ACC_POS;
                else if (item.close_end_switch)
                    phase_next = PH_CLOSED;
            default:
                phase_next = phase_reg;
        endcase
    end

    // speed: entry value of the new phase, homing drive, or held
    always_comb
    begin
        if (phase_reg == PH_HOMING)
            speed_next = to_close ? -low_pos : low_pos;
        else
            speed_next = speed_reg;
        if (phase_next != phase_reg)
        begin
            case (phase_next)
                PH_OPEN, PH_CLOSED: speed_next = '0;
                PH_ACC_POS:         speed_next = high_pos;
                PH_ACC_NEG:         speed_next = -high_pos;
                PH_DEC_POS:         speed_next = low_pos;
                PH_DEC_NEG:         speed_next = -low_pos;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HOMING;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg <= phase_next;
                speed_reg <= speed_next;
            end
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.phase_code  = phase_reg;
    assign result_out.drive_speed = speed_reg;

endmodule

FILE: rtl/door_drive_profile_fsm.sv
// ----------------------------------------------------------------------------
// door_drive_profile_fsm
// door drive motion phase machine with programmable slow and fast speeds
//
//   channel      dir  beat contents
//   item_in      in   close_request, four position switch levels
//   result_out   out  phase_code, drive_speed after the tick
//   apb          in   low_speed at 0x0, high_speed at 0x4
//
// one tick per cycle sustained while result beats are taken; a tick is
// loaded into the input register at the accepting edge and then into the
// phase/speed register (the result beat) when the machine takes it
// the phase/speed register is also the result beat, so a stalled result
// holds the machine while the input register can still take one more tick
// reset puts the machine in homing at speed zero, speeds at 100 and 1000
// ----------------------------------------------------------------------------
module door_drive_profile_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    ddp_in_if.sink                      item_in,
    ddp_out_if.source                   result_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ddp_pkg::ADDR_W-1:0]  paddr,
    input  logic [ddp_pkg::DATA_W-1:0]  pwdata,
    output logic [ddp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import ddp_pkg::*;

    ddp_cfg_t  cfg;
    ddp_item_t item;
    logic      item_valid;
    logic      take;

    ddp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ddp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ddp_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg),
        .take       (take),
        .result_out (result_out)
    );

endmodule

FILE: rtl/ddp_checker.sv
// ----------------------------------------------------------------------------
// ddp_checker
// port-level checks on result beats of the door drive block
// ----------------------------------------------------------------------------
`include "door_drive_profile_fsm_macros.svh"

module ddp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [ddp_pkg::PHASE_W-1:0] phase_code,
    input logic signed [ddp_pkg::SPEED_W-1:0] drive_speed
);
    import ddp_pkg::*;

    // stalled beat holds its payload
    `DDP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(phase_code) && $stable(drive_speed))

    // only defined phases ever show up
    `DDP_ASSERT_IMPL(a_phase_range, out_valid, phase_code <= PH_DEC_NEG)

    // resting at an end means the motor is stopped
    `DDP_ASSERT_IMPL(a_rest_stopped, out_valid && (phase_code == PH_OPEN || phase_code == PH_CLOSED), drive_speed == 16'sd0)

    // positive ramp phases never drive in the negative direction
    `DDP_ASSERT_IMPL(a_ramp_sign, out_valid && (phase_code == PH_ACC_POS || phase_code == PH_DEC_POS), !drive_speed[15])

endmodule

bind door_drive_profile_fsm ddp_checker u_ddp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .phase_code  (result_out.phase_code),
    .drive_speed (result_out.drive_speed)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// door drive profile testbench
// drives switch ticks through the valid/ready input channel with random
// gaps, mirrors the phase machine and the speed registers in the bench,
// and checks every phase/speed result beat in order against the mirror
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ddp_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_LOW_SPEED  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_HIGH_SPEED = 3'd4;
    localparam int RUN_ITEMS = 171;

    typedef struct {
        logic [PHASE_W-1:0]        phase;
        logic signed [SPEED_W-1:0] speed;
    } profile_beat_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    ddp_in_if  tick_if ();
    ddp_out_if res_if ();

    door_drive_profile_fsm i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (tick_if.sink),
        .result_out (res_if.source),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // bench copy of the machine
    phase_t                    door_phase;
    logic signed [SPEED_W-1:0] door_speed;
    logic [MAG_W-1:0]          slow_mag;
    logic [MAG_W-1:0]          fast_mag;

    ddp_item_t     pending_ticks[$];
    profile_beat_t expected_beats[$];

    int  fail_count;
    bit  tick_taken;
    bit  no_idle;
    int  tick_gap;
    int  result_gap;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [SPEED_W-1:0] entry_speed(phase_t ph,
                                                            logic signed [SPEED_W-1:0] held);
        case (ph)
            PH_OPEN, PH_CLOSED: return '0;
            PH_ACC_POS:         return {1'b0, fast_mag};
            PH_ACC_NEG:         return -{1'b0, fast_mag};
            PH_DEC_POS:         return {1'b0, slow_mag};
            PH_DEC_NEG:         return -{1'b0, slow_mag};
            default:            return held;
        endcase
    endfunction

    task automatic advance_door(ddp_item_t t);
        phase_t                    nxt;
        logic signed [SPEED_W-1:0] spd;
        profile_beat_t             beat;
        nxt = door_phase;
        spd = door_speed;
        case (door_phase)
            PH_HOMING:
                if (t.close_request)
                begin
                    spd = -{1'b0, slow_mag};
                    if (t.close_end_switch)
                        nxt = PH_CLOSED;
                end
                else
                begin
                    spd = {1'b0, slow_mag};
                    if (t.open_end_switch)
                        nxt = PH_OPEN;
                end
            PH_OPEN:
                if (t.close_request)
                    nxt = PH_ACC_NEG;
            PH_CLOSED:
                if (!t.close_request)
                    nxt = PH_ACC_POS;
            PH_ACC_POS:
                if (t.close_request)
                    nxt = PH_DEC_NEG;
                else if (t.close_near_switch)
                    nxt = PH_CRUISE_POS;
            PH_ACC_NEG:
                if (!t.close_request)
                    nxt = PH_DEC_POS;
                else if (t.open_near_switch)
                    nxt = PH_CRUISE_NEG;
            PH_CRUISE_POS:
                if (t.close_request)
                    nxt = PH_CRUISE_NEG;
                else if (t.open_near_switch)
                    nxt = PH_DEC_POS;
            PH_CRUISE_NEG:
                if (!t.close_request)
                    nxt = PH_CRUISE_POS;
                else if (t.close_near_switch)
                    nxt = PH_DEC_NEG;
            PH_DEC_POS:
                if (t.close_request)
                    nxt = PH_ACC_NEG;
                else if (t.open_end_switch)
                    nxt = PH_OPEN;
            PH_DEC_NEG:
                if (!t.close_request)
                    nxt = PH_ACC_POS;
                else if (t.close_end_switch)
                    nxt = PH_CLOSED;
            default:
                nxt = door_phase;
        endcase
        if (nxt != door_phase)
            spd = entry_speed(nxt, spd);
        door_phase = nxt;
        door_speed = spd;
        beat.phase = nxt;
        beat.speed = spd;
        expected_beats.push_back(beat);
    endtask

    // accepted ticks and register writes, mirrored at the clock edge
    always @(posedge clk)
    begin
        tick_taken = rst_n && tick_if.valid && tick_if.ready;
        if (tick_taken)
        begin
            advance_door(ddp_item_t'({tick_if.close_request, tick_if.open_end_switch,
                                      tick_if.open_near_switch, tick_if.close_near_switch,
                                      tick_if.close_end_switch}));
        end
        if (rst_n && psel && penable && pwrite && pready)
        begin
            if (paddr == ADDR_LOW_SPEED)
                slow_mag = pwdata[MAG_W-1:0];
            else if (paddr == ADDR_HIGH_SPEED)
                fast_mag = pwdata[MAG_W-1:0];
        end
    end

    // result beat checker
    always @(posedge clk)
    begin : check_results
        profile_beat_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, phase %0d speed %0d",
                         $time, res_if.phase_code, res_if.drive_speed);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (res_if.phase_code !== want.phase)
                begin
                    $display("%0t: phase mismatch, expected %0d, actual %0d",
                             $time, want.phase, res_if.phase_code);
                    fail_count++;
                end
                if (res_if.drive_speed !== want.speed)
                begin
                    $display("%0t: speed mismatch, expected %0d, actual %0d",
                             $time, want.speed, res_if.drive_speed);
                    fail_count++;
                end
            end
        end
    end

    // tick driver
    always @(negedge clk)
    begin : drive_ticks
        ddp_item_t nxt;
        bit        go;
        if (rst_n && (!tick_if.valid || tick_taken))
        begin
            go = 1'b0;
            if (tick_gap > 0)
                tick_gap--;
            else if (!no_idle && $urandom_range(0, 7) == 0)
                tick_gap = $urandom_range(0, 5);
            else
                go = (pending_ticks.size() != 0);
            if (go)
            begin
                nxt = pending_ticks.pop_front();
                tick_if.valid             <= 1'b1;
                tick_if.close_request     <= nxt.close_request;
                tick_if.open_end_switch   <= nxt.open_end_switch;
                tick_if.open_near_switch  <= nxt.open_near_switch;
                tick_if.close_near_switch <= nxt.close_near_switch;
                tick_if.close_end_switch  <= nxt.close_end_switch;
            end
            else
                tick_if.valid <= 1'b0;
        end
    end

    // result sink with random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_gap > 0)
            begin
                result_gap--;
                res_if.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 6) == 0)
            begin
                result_gap = $urandom_range(0, 5);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || tick_if.valid || expected_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper data bits are random so the 15-bit masking is exercised
    task automatic set_speeds(logic [MAG_W-1:0] slow, logic [MAG_W-1:0] fast);
        logic [DATA_W-1:0] junk;
        wait_drained();
        junk = $urandom;
        apb_write(ADDR_LOW_SPEED, {junk[DATA_W-1:MAG_W], slow});
        junk = $urandom;
        apb_write(ADDR_HIGH_SPEED, {junk[DATA_W-1:MAG_W], fast});
    endtask

    // mostly door travel between the ends with switch levels that follow the
    // position, mixed with raw noise and the odd glitching switch
    task automatic queue_door_run(int count);
        int        span;
        int        pos;
        bit        to_close;
        ddp_item_t t;
        span = $urandom_range(4, 20);
        pos = $urandom_range(0, span);
        to_close = $urandom_range(0, 1);
        repeat (count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 15) == 0)
                    to_close = !to_close;
                if ($urandom_range(0, 3) != 0)
                begin
                    if (to_close && pos < span)
                        pos++;
                    else if (!to_close && pos > 0)
                        pos--;
                end
                t.close_request     = to_close;
                t.open_end_switch   = (pos == 0);
                t.open_near_switch  = (pos <= 2);
                t.close_near_switch = (pos >= span - 2);
                t.close_end_switch  = (pos == span);
                if ($urandom_range(0, 9) == 0)
                    t = t ^ (5'b1 << $urandom_range(0, 3));
            end
            else
                t = 5'($urandom_range(0, 31));
            pending_ticks.push_back(t);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tick_if.valid = 1'b0;
        tick_if.close_request = 1'b0;
        tick_if.open_end_switch = 1'b0;
        tick_if.open_near_switch = 1'b0;
        tick_if.close_near_switch = 1'b0;
        tick_if.close_end_switch = 1'b0;
        res_if.ready = 1'b0;
        door_phase = PH_HOMING;
        door_speed = '0;
        slow_mag = LOW_SPEED_RESET;
        fast_mag = HIGH_SPEED_RESET;
        fail_count = 0;
        tick_taken = 1'b0;
        no_idle = 1'b0;
        tick_gap = 0;
        result_gap = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed walk through every phase at the reset speeds
        // bit order: close_request, open_end, open_near, close_near, close_end
        pending_ticks.push_back(5'b1_0000); // homing toward closed
        pending_ticks.push_back(5'b0_0000); // homing toward open
        pending_ticks.push_back(5'b1_1111); // homing reaches closed end
        pending_ticks.push_back(5'b0_0000); // closed -> acc pos
        pending_ticks.push_back(5'b0_0010); // acc pos -> cruise pos
        pending_ticks.push_back(5'b0_0000);
        pending_ticks.push_back(5'b0_0100); // cruise pos -> dec pos
        pending_ticks.push_back(5'b1_0000); // dec pos reversal -> acc neg
        pending_ticks.push_back(5'b0_0000); // acc neg reversal -> dec pos
        pending_ticks.push_back(5'b0_1000); // dec pos -> open
        pending_ticks.push_back(5'b0_0111); // open holds
        pending_ticks.push_back(5'b1_0000); // open -> acc neg
        pending_ticks.push_back(5'b1_0010); // acc neg ignores close near
        pending_ticks.push_back(5'b1_0100); // acc neg -> cruise neg
        pending_ticks.push_back(5'b0_0000); // cruise neg -> cruise pos
        pending_ticks.push_back(5'b1_0000); // cruise pos -> cruise neg
        pending_ticks.push_back(5'b1_0010); // cruise neg -> dec neg
        pending_ticks.push_back(5'b0_0000); // dec neg reversal -> acc pos
        pending_ticks.push_back(5'b1_0000); // acc pos reversal -> dec neg
        pending_ticks.push_back(5'b1_0001); // dec neg -> closed
        pending_ticks.push_back(5'b0_1111); // closed -> acc pos
        pending_ticks.push_back(5'b1_1111); // acc pos -> dec neg
        pending_ticks.push_back(5'b1_0001); // dec neg -> closed
        pending_ticks.push_back(5'b1_1110); // closed holds

        set_speeds(15'd0, 15'h7fff);
        queue_door_run(RUN_ITEMS);
        set_speeds(15'h7fff, 15'd0);
        queue_door_run(RUN_ITEMS);
        set_speeds(15'h7fff, 15'h7fff);
        queue_door_run(RUN_ITEMS);
        set_speeds(15'd0, 15'd0);
        queue_door_run(RUN_ITEMS);
        set_speeds(MAG_W'($urandom_range(0, 32767)), MAG_W'($urandom_range(0, 32767)));
        queue_door_run(RUN_ITEMS);
        set_speeds(MAG_W'($urandom_range(0, 32767)), MAG_W'($urandom_range(0, 32767)));
        no_idle = 1'b1;
        queue_door_run(RUN_ITEMS);

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && expected_beats.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #400000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
